// ===== hdl/acfr_pkg.sv =====
// Package for the addressed CRC frame receiver.
// Holds the channel beat types, register map, controller/datapath command structs
// and the CRC-16/MODBUS byte update. Depends on nothing.
package acfr_pkg;

  localparam int DEFAULT_PAYLOAD_DEPTH = 32;
  localparam int LEN_W = 7;

  localparam logic [7:0]  LOCAL_ADDR_RESET = 8'd0;
  localparam logic [7:0]  BCAST_ADDR_RESET = 8'd255;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd100;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // APB register map, word index into paddr[3:2].
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] REG_BCAST_ADDR = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       frame_address;
    logic [LEN_W-1:0] frame_length;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_ADDR = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic step;        // an input beat is taken this cycle
    logic rd_start;    // restart the readout index
    logic rd_next;     // advance the readout index
    logic load_byte;   // load a payload result into the output register
    logic load_empty;  // load the empty-frame result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic frame_good;  // the byte being taken completes an accepted frame
    logic frame_empty; // that frame stored no payload
    logic rd_last;     // the readout index points at the final stored byte
  } dp_sts_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/acfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No reset on the storage. Depends on nothing.
module acfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/acfr_datapath.sv =====
// Datapath of the frame receiver: parser registers, running CRC, idle counter,
// payload store, readout index and output register. Depends on acfr_pkg, acfr_ram.
module acfr_datapath #(
  parameter int PAYLOAD_DEPTH = acfr_pkg::DEFAULT_PAYLOAD_DEPTH,
  parameter int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acfr_pkg::in_item_t  in_data_i,
  input  logic [7:0]          local_addr_i,
  input  logic [7:0]          bcast_addr_i,
  input  logic [15:0]         timeout_i,
  input  acfr_pkg::dp_cmd_t   cmd_i,
  output acfr_pkg::dp_sts_t   sts_o,
  output acfr_pkg::out_item_t out_data_o
);

  localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);
  localparam logic [acfr_pkg::LEN_W-1:0] DEPTH_L = acfr_pkg::LEN_W'(PAYLOAD_DEPTH);

  acfr_pkg::phase_e phase_q, phase_d, ph;
  logic [7:0]  addr_q, addr_d, addr_e;
  logic [7:0]  len_q, len_d, len_e;
  logic [7:0]  cnt_q, cnt_d, cnt_e, cnt_inc;
  logic [15:0] crc_q, crc_d, crc_e;
  logic [7:0]  lo_q, lo_d, lo_e;
  logic [15:0] idle_q, idle_d;
  logic        late, good, we;
  logic [7:0]  b;

  logic [7:0]                   frame_addr_q;
  logic [acfr_pkg::LEN_W-1:0]   frame_len_q, len_cap;
  logic [ADDR_W-1:0]            rd_idx_q;
  logic [7:0]                   rdata;
  acfr_pkg::out_item_t          out_q;

  assign b = in_data_i.rx_byte;

  always_comb begin
    // A byte after too long a gap first restarts the parser.
    late   = (idle_q > timeout_i);
    ph     = late ? acfr_pkg::PH_ADDR : phase_q;
    addr_e = late ? 8'd0 : addr_q;
    len_e  = late ? 8'd0 : len_q;
    cnt_e  = late ? 8'd0 : cnt_q;
    crc_e  = late ? acfr_pkg::CRC_INIT : crc_q;
    lo_e   = late ? 8'd0 : lo_q;
    cnt_inc = cnt_e + 8'd1;

    phase_d = phase_q;
    addr_d  = addr_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    lo_d    = lo_q;
    idle_d  = idle_q;
    we      = 1'b0;
    good    = 1'b0;

    if (cmd_i.step && in_data_i.opcode == acfr_pkg::OP_TICK) begin
      if (idle_q != acfr_pkg::IDLE_MAX) begin
        idle_d = idle_q + 16'd1;
      end
    end else if (cmd_i.step) begin
      idle_d  = 16'd0;
      phase_d = ph;
      addr_d  = addr_e;
      len_d   = len_e;
      cnt_d   = cnt_e;
      crc_d   = crc_e;
      lo_d    = lo_e;
      unique case (ph)
        acfr_pkg::PH_ADDR: begin
          addr_d  = b;
          crc_d   = acfr_pkg::crc_feed(acfr_pkg::CRC_INIT, b);
          phase_d = acfr_pkg::PH_LEN;
        end
        acfr_pkg::PH_LEN: begin
          len_d   = b;
          crc_d   = acfr_pkg::crc_feed(crc_e, b);
          cnt_d   = 8'd0;
          phase_d = (b != 8'd0) ? acfr_pkg::PH_DATA : acfr_pkg::PH_CRC;
        end
        acfr_pkg::PH_DATA: begin
          // Bytes past the store depth are counted but not stored or checked.
          if (cnt_e < DEPTH_B) begin
            we    = 1'b1;
            crc_d = acfr_pkg::crc_feed(crc_e, b);
          end
          if (cnt_inc >= len_e) begin
            cnt_d   = 8'd0;
            phase_d = acfr_pkg::PH_CRC;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        acfr_pkg::PH_CRC: begin
          if (cnt_e == 8'd0) begin
            lo_d  = b;
            cnt_d = 8'd1;
          end else begin
            good = ({b, lo_e} == crc_e) &&
                   (addr_e == local_addr_i || addr_e == bcast_addr_i);
            phase_d = acfr_pkg::PH_ADDR;
            addr_d  = 8'd0;
            len_d   = 8'd0;
            cnt_d   = 8'd0;
            crc_d   = acfr_pkg::CRC_INIT;
            lo_d    = 8'd0;
          end
        end
        default: begin
          phase_d = acfr_pkg::PH_ADDR;
          addr_d  = 8'd0;
          len_d   = 8'd0;
          cnt_d   = 8'd0;
          crc_d   = acfr_pkg::CRC_INIT;
          lo_d    = 8'd0;
        end
      endcase
    end
  end

  assign len_cap = (len_e < DEPTH_B) ? len_e[acfr_pkg::LEN_W-1:0] : DEPTH_L;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= acfr_pkg::PH_ADDR;
      addr_q  <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      crc_q   <= acfr_pkg::CRC_INIT;
      lo_q    <= 8'd0;
      idle_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      lo_q    <= lo_d;
      idle_q  <= idle_d;
    end
  end

  acfr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_e[ADDR_W-1:0]),
    .wdata_i(b),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  // Frame header and readout registers; contents only matter once loaded.
  always_ff @(posedge clk_i) begin
    if (good) begin
      frame_addr_q <= addr_e;
      frame_len_q  <= len_cap;
    end
    if (cmd_i.rd_start) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= rd_idx_q + ADDR_W'(1);
    end
    if (cmd_i.load_byte) begin
      out_q.frame_address <= frame_addr_q;
      out_q.frame_length  <= frame_len_q;
      out_q.payload_byte  <= rdata;
      out_q.byte_valid    <= 1'b1;
      out_q.last          <= sts_o.rd_last;
    end else if (cmd_i.load_empty) begin
      out_q.frame_address <= frame_addr_q;
      out_q.frame_length  <= '0;
      out_q.payload_byte  <= 8'd0;
      out_q.byte_valid    <= 1'b0;
      out_q.last          <= 1'b1;
    end
  end

  assign sts_o.frame_good  = good;
  assign sts_o.frame_empty = (len_e == 8'd0);
  assign sts_o.rd_last     = ((acfr_pkg::LEN_W'(rd_idx_q) + acfr_pkg::LEN_W'(1)) == frame_len_q);
  assign out_data_o        = out_q;

  a_idle_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && in_data_i.opcode == acfr_pkg::OP_TICK && idle_q == acfr_pkg::IDLE_MAX)
    |=> idle_q == acfr_pkg::IDLE_MAX)
    else $error("idle tick counter wrapped");

  a_no_step_past_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_next |-> !sts_o.rd_last)
    else $error("readout advanced past the final stored byte");

  a_readout_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_start |=> frame_len_q != '0)
    else $error("byte readout started for a frame with no stored payload");

endmodule

// ===== hdl/acfr_controller.sv =====
// Controller of the frame receiver: input handshake, readout sequencing and
// output valid. Depends on acfr_pkg.
module acfr_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  acfr_pkg::dp_sts_t sts_i,
  output acfr_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_LOAD  = 4'b0100,
    S_EMPTY = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.step = in_valid_i;
        if (in_valid_i && sts_i.frame_good) begin
          if (sts_i.frame_empty) begin
            state_d = S_EMPTY;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d        = S_READ;
          end
        end
      end
      // The store read issued here lands in the RAM output register.
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load_byte = 1'b1;
          if (sts_i.rd_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          cmd_o.load_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_byte || cmd_o.load_empty) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state lost its one-hot code");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_byte || cmd_o.load_empty) |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while holding an untaken beat");

  a_frame_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && sts_i.frame_good) |=> state_q != S_IDLE)
    else $error("accepted frame did not start its readout");

  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_byte && cmd_o.load_empty))
    else $error("two result loads in one cycle");

endmodule

// ===== hdl/addressed_crc_frame_receiver_top.sv =====
// Top level of the addressed CRC-16/MODBUS frame receiver.
// Holds the APB register file and joins controller and datapath.
// Depends on acfr_pkg, acfr_controller, acfr_datapath (and acfr_ram below it).
//
// Usage: the input channel carries beats that are either a received serial
// byte or a tick. A frame is address, length, payload and a CRC-16/MODBUS,
// low byte first. A frame whose CRC matches and whose address is the local
// or the broadcast address comes out on the output channel as one beat per
// stored payload byte (last set on the final one), or as one empty beat when
// no payload was stored. Other frames are dropped silently. Input beats are
// taken only while the controller is idle, and no result appears for most.
// After the closing CRC byte of an accepted frame the input stalls while the
// payload is read out of the store: each byte goes through a read state and
// then a load state, as the single-read-port store has a registered read.
// When the output side stalls, the readout waits and the input stays blocked
// until the final beat is loaded into the output register. Reset clears the
// parser, the idle counter and the registers to their defaults (local
// address 0, broadcast 255, timeout 100 ticks); the payload store is not
// cleared.
module addressed_crc_frame_receiver_top #(
  parameter int PAYLOAD_DEPTH = acfr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  acfr_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output acfr_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [acfr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [7:0]  local_addr_q, bcast_addr_q;
  logic [15:0] timeout_q;
  logic [1:0]  reg_idx;
  logic        wr_en;

  acfr_pkg::dp_cmd_t cmd;
  acfr_pkg::dp_sts_t sts;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= acfr_pkg::LOCAL_ADDR_RESET;
      bcast_addr_q <= acfr_pkg::BCAST_ADDR_RESET;
      timeout_q    <= acfr_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        acfr_pkg::REG_LOCAL_ADDR: local_addr_q <= pwdata[7:0];
        acfr_pkg::REG_BCAST_ADDR: bcast_addr_q <= pwdata[7:0];
        acfr_pkg::REG_TIMEOUT:    timeout_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      acfr_pkg::REG_LOCAL_ADDR: prdata = {24'd0, local_addr_q};
      acfr_pkg::REG_BCAST_ADDR: prdata = {24'd0, bcast_addr_q};
      acfr_pkg::REG_TIMEOUT:    prdata = {16'd0, timeout_q};
      default:                  prdata = 32'd0;
    endcase
  end

  acfr_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acfr_datapath #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .local_addr_i(local_addr_q),
    .bcast_addr_i(bcast_addr_q),
    .timeout_i   (timeout_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
